/* hw/rtl/crc_checked_frame_receiver_defines.svh */
// ----------------------------------------------------------------------------
// crc checked frame receiver assertion macros
// shared concurrent assertion forms, clocked on clk, off during reset
// ----------------------------------------------------------------------------
`ifndef CRC_CHECKED_FRAME_RECEIVER_DEFINES_SVH
`define CRC_CHECKED_FRAME_RECEIVER_DEFINES_SVH

// same-cycle implication
`define CRCFR_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("crcfr assertion failed");

// next-cycle implication
`define CRCFR_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("crcfr assertion failed");

`endif

/* hw/rtl/crcfr_pkg.sv */
// ----------------------------------------------------------------------------
// crcfr_pkg
// types, codes and the crc-32 byte update shared by the frame receiver
// ----------------------------------------------------------------------------
package crcfr_pkg;

	localparam int LEN_W       = 18;
	localparam int CRC_W       = 32;
	localparam int QUEUE_DEPTH = 4;

	localparam logic [CRC_W-1:0] CRC_POLY = 32'hEDB88320;
	localparam logic [CRC_W-1:0] CRC_INIT = 32'hFFFFFFFF;

	typedef enum logic [1:0] {
		CMD_BEGIN = 2'd0,
		CMD_ABORT = 2'd1,
		CMD_END   = 2'd2,
		CMD_DATA  = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ST_READY   = 3'd0,
		ST_ABORTED = 3'd1,
		ST_LENERR  = 3'd2,
		ST_CRCOK   = 3'd3,
		ST_CRCFAIL = 3'd4,
		ST_DONE    = 3'd5,
		ST_ACK     = 3'd6
	} status_t;

	typedef struct packed {
		cmd_t             cmd;
		logic [LEN_W-1:0] len;
		logic [CRC_W-1:0] crc;
		logic [7:0]       data;
		logic             chunk_last;
	} item_t;

	function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc,
		input logic [7:0] b);
		logic [CRC_W-1:0] c;
		c = crc ^ {24'd0, b};
		for (int i = 0; i < 8; i++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

/* hw/rtl/crcfr_queue.sv */
// ----------------------------------------------------------------------------
// crcfr_queue
// small register queue of classified commands between front and back
// ----------------------------------------------------------------------------
module crcfr_queue #(
	parameter int DEPTH = 4
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            wr_en,
	input  crcfr_pkg::item_t wr_item,
	output logic            full,
	input  logic            rd_en,
	output crcfr_pkg::item_t rd_item,
	output logic            q_empty
);
	import crcfr_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	item_t         mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] cnt_q;

	assign full    = (cnt_q == CW'(DEPTH));
	assign q_empty = (cnt_q == '0);
	assign rd_item = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({wr_en, rd_en})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

/* hw/rtl/crcfr_front.sv */
// ----------------------------------------------------------------------------
// crcfr_front
// accepts input transactions, decodes the command and clamps the length
// ----------------------------------------------------------------------------
module crcfr_front #(
	parameter int MAX_FRAME_BYTES = 131072
) (
	input  logic             push,
	input  logic             full,
	input  logic [1:0]       cmd,
	input  logic [17:0]      frame_length,
	input  logic [31:0]      expected_crc,
	input  logic [7:0]       data_byte,
	input  logic             chunk_last,
	output logic             wr_en,
	output crcfr_pkg::item_t wr_item
);
	import crcfr_pkg::*;

	localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_FRAME_BYTES);

	assign wr_en = push && !full;

	always_comb begin
		wr_item.cmd        = cmd_t'(cmd);
		wr_item.len        = (frame_length > MAX_LEN) ? MAX_LEN : frame_length;
		wr_item.crc        = expected_crc;
		wr_item.data       = data_byte;
		wr_item.chunk_last = chunk_last;
	end

endmodule

/* hw/rtl/crcfr_back.sv */
// ----------------------------------------------------------------------------
// crcfr_back
// executes queued commands: transfer state, crc-32, ack logic, result register
// ----------------------------------------------------------------------------
module crcfr_back #(
	parameter int ACK_INTERVAL = 512
) (
	input  logic             clk,
	input  logic             arst_n,
	input  crcfr_pkg::item_t rd_item,
	input  logic             q_empty,
	output logic             rd_en,
	output logic             empty,
	input  logic             pop,
	output crcfr_pkg::status_t status,
	output logic [31:0]      value,
	output logic             last_result
);
	import crcfr_pkg::*;

	localparam int RW = (ACK_INTERVAL > 1) ? $clog2(ACK_INTERVAL) : 1;

	logic             xfer_q;
	logic [LEN_W-1:0] offset_q;
	logic [LEN_W-1:0] flen_q;
	logic [CRC_W-1:0] target_q;
	logic [CRC_W-1:0] crc_q;
	logic [RW-1:0]    rem_q;
	logic             crossed_q;
	logic             pend_q;
	logic             out_valid_q;
	status_t          status_q;
	logic [CRC_W-1:0] value_q;
	logic             last_q;

	logic [CRC_W-1:0] crc_next;
	logic [CRC_W-1:0] got;
	logic [LEN_W-1:0] off_inc;
	logic [LEN_W-1:0] off_new;
	logic             take;
	logic             wrap;
	logic             cross_new;
	logic             ack;
	logic             end_ok;
	logic             produce;
	logic             slot_free;
	logic             issue;
	logic             load_out;
	status_t          o_status;
	logic [CRC_W-1:0] o_value;
	logic             o_last;

	assign crc_next  = crc_byte(crc_q, rd_item.data);
	assign got       = ~crc_q;
	assign take      = offset_q < flen_q;
	assign off_inc   = offset_q + 1'b1;
	assign off_new   = take ? off_inc : offset_q;
	assign wrap      = (rem_q == RW'(ACK_INTERVAL - 1));
	assign cross_new = crossed_q | (take & wrap);
	assign ack       = cross_new || (off_new == flen_q);
	assign end_ok    = xfer_q && (offset_q == flen_q);
	assign slot_free = !out_valid_q || pop;

	always_comb begin
		case (rd_item.cmd)
			CMD_DATA: produce = xfer_q && rd_item.chunk_last && ack;
			default:  produce = 1'b1;
		endcase
	end

	assign issue = !pend_q && !q_empty && (!produce || slot_free);
	assign rd_en = issue;

	// result selection
	always_comb begin
		load_out = 1'b0;
		o_status = ST_DONE;
		o_value  = '0;
		o_last   = 1'b1;
		if (pend_q) begin
			load_out = slot_free;
		end else if (issue) begin
			load_out = produce;
			case (rd_item.cmd)
				CMD_BEGIN: o_status = ST_READY;
				CMD_ABORT: o_status = ST_ABORTED;
				CMD_END: begin
					if (!end_ok) begin
						o_status = ST_LENERR;
					end else if (got != target_q) begin
						o_status = ST_CRCFAIL;
						o_value  = got;
						o_last   = 1'b0;
					end else begin
						o_status = ST_CRCOK;
						o_last   = 1'b0;
					end
				end
				CMD_DATA: begin
					o_status = ST_ACK;
					o_value  = CRC_W'(off_new);
				end
				default: o_status = ST_DONE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			status_q <= o_status;
			value_q  <= o_value;
			last_q   <= o_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			xfer_q      <= 1'b0;
			offset_q    <= '0;
			flen_q      <= '0;
			target_q    <= '0;
			crc_q       <= CRC_INIT;
			rem_q       <= '0;
			crossed_q   <= 1'b0;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
			if (pend_q) begin
				if (slot_free) begin
					pend_q <= 1'b0;
				end
			end else if (issue) begin
				case (rd_item.cmd)
					CMD_BEGIN: begin
						flen_q    <= rd_item.len;
						target_q  <= rd_item.crc;
						xfer_q    <= 1'b1;
						offset_q  <= '0;
						crc_q     <= CRC_INIT;
						rem_q     <= '0;
						crossed_q <= 1'b0;
					end
					CMD_DATA: begin
						if (xfer_q) begin
							if (take) begin
								crc_q    <= crc_next;
								offset_q <= off_inc;
								rem_q    <= wrap ? '0 : rem_q + 1'b1;
							end
							crossed_q <= rd_item.chunk_last ? 1'b0 : cross_new;
						end
					end
					CMD_END: begin
						if (end_ok) begin
							pend_q <= 1'b1;
						end
						if (end_ok && (got == target_q)) begin
							xfer_q <= 1'b0;
						end else begin
							xfer_q    <= 1'b0;
							offset_q  <= '0;
							target_q  <= '0;
							crc_q     <= CRC_INIT;
							rem_q     <= '0;
							crossed_q <= 1'b0;
						end
					end
					default: begin
						xfer_q    <= 1'b0;
						offset_q  <= '0;
						target_q  <= '0;
						crc_q     <= CRC_INIT;
						rem_q     <= '0;
						crossed_q <= 1'b0;
					end
				endcase
			end
		end
	end

	assign empty       = !out_valid_q;
	assign status      = status_q;
	assign value       = value_q;
	assign last_result = last_q;

endmodule

/* hw/rtl/crc_checked_frame_receiver.sv */
// ----------------------------------------------------------------------------
// crc_checked_frame_receiver
// receive side of a chunked frame transfer with running crc-32 check
// ----------------------------------------------------------------------------
// input channel: push/full, one command per transaction (begin, abort, end,
//   data byte); a transaction happens when push is high and full is low
// result channel: empty/pop, the oldest result sits on status, value and
//   last_result while empty is low; pop takes it
// a command passes through the command queue and then the result register
//   before its result is on the ports, and waits while the result side is busy
// throughput: one command per cycle while the result side is free; an end
//   command that checks the crc holds the execute unit for its two results
// the front decodes into a four-entry command queue; the execute unit owns
//   the transfer state and a single result register
// reset empties the queue and the result register and leaves no transfer
//   active; full is low right after reset
// when the result side stalls, commands that give no result still retire,
//   others wait, the queue fills and full rises
// ----------------------------------------------------------------------------
module crc_checked_frame_receiver #(
	parameter int ACK_INTERVAL    = 512,
	parameter int MAX_FRAME_BYTES = 131072
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [1:0]  cmd,
	input  logic [17:0] frame_length,
	input  logic [31:0] expected_crc,
	input  logic [7:0]  data_byte,
	input  logic        chunk_last,
	output logic        empty,
	input  logic        pop,
	output logic [2:0]  status,
	output logic [31:0] value,
	output logic        last_result
);
	import crcfr_pkg::*;

	logic    wr_en;
	item_t   wr_item;
	logic    rd_en;
	item_t   rd_item;
	logic    q_empty;
	status_t status_int;

	crcfr_front #(
		.MAX_FRAME_BYTES(MAX_FRAME_BYTES)
	) u_front (
		.push        (push),
		.full        (full),
		.cmd         (cmd),
		.frame_length(frame_length),
		.expected_crc(expected_crc),
		.data_byte   (data_byte),
		.chunk_last  (chunk_last),
		.wr_en       (wr_en),
		.wr_item     (wr_item)
	);

	crcfr_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (wr_en),
		.wr_item(wr_item),
		.full   (full),
		.rd_en  (rd_en),
		.rd_item(rd_item),
		.q_empty(q_empty)
	);

	crcfr_back #(
		.ACK_INTERVAL(ACK_INTERVAL)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.rd_item    (rd_item),
		.q_empty    (q_empty),
		.rd_en      (rd_en),
		.empty      (empty),
		.pop        (pop),
		.status     (status_int),
		.value      (value),
		.last_result(last_result)
	);

	assign status = status_int;

endmodule

/* hw/rtl/crcfr_checker.sv */
// ----------------------------------------------------------------------------
// crcfr_checker
// port-level checks on the frame receiver result stream, bound to the top
// ----------------------------------------------------------------------------
`include "crc_checked_frame_receiver_defines.svh"

module crcfr_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        empty,
	input logic        pop,
	input logic [2:0]  status,
	input logic [31:0] value,
	input logic        last_result
);
	import crcfr_pkg::*;

	logic verdict;

	assign verdict = !empty && (status == ST_CRCOK || status == ST_CRCFAIL);

	// held result stays put
	`CRCFR_ASSERT_NEXT(a_hold, !empty && !pop, !empty && $stable(status) && $stable(value))

	// crc verdict is never the final result of an end transaction
	`CRCFR_ASSERT_IMPL(a_verdict_not_last, verdict, !last_result)

	// crc verdict is followed directly by done
	`CRCFR_ASSERT_NEXT(a_done_follows, verdict && pop, !empty && status == ST_DONE && last_result)

	// value is zero except for crc fail and ack
	`CRCFR_ASSERT_IMPL(a_value_zero, !empty && status != ST_CRCFAIL && status != ST_ACK, value == '0)

endmodule

bind crc_checked_frame_receiver crcfr_checker u_crcfr_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.empty      (empty),
	.pop        (pop),
	.status     (status),
	.value      (value),
	.last_result(last_result)
);

/* verif/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc checked frame receiver testbench
// Drives begin, abort, end and data commands through the push/full side and
// pops results through the empty/pop side. A predictor of the receiver tracks
// the transfer state, the running crc-32, the byte offset and the chunk ack
// rule, and each popped transaction is compared field by field with the
// oldest awaited reply. Directed cases first, then random frames that are
// mostly well formed, under three idling patterns, then a frame that crosses
// an ack boundary and a begin with an oversized length.
// ----------------------------------------------------------------------------
module testbench;
	import crcfr_pkg::*;

	localparam int ACK_INTERVAL    = 512;
	localparam int MAX_FRAME_BYTES = 131072;
	localparam int STALL_LIMIT     = 4000;
	localparam int DRAIN_CYCLES    = 64;
	localparam int REPORT_CAP      = 100;

	typedef struct {
		status_t          status;
		logic [CRC_W-1:0] value;
		logic             last;
	} receiver_reply_t;

	logic              clk          = 1'b0;
	logic              arst_n       = 1'b0;
	logic              push         = 1'b0;
	logic              full;
	logic [1:0]        cmd          = '0;
	logic [LEN_W-1:0]  frame_length = '0;
	logic [CRC_W-1:0]  expected_crc = '0;
	logic [7:0]        data_byte    = '0;
	logic              chunk_last   = 1'b0;
	logic              empty;
	logic              pop          = 1'b0;
	logic [2:0]        status;
	logic [CRC_W-1:0]  value;
	logic              last_result;

	// receiver state as predicted
	logic              rx_active;
	logic [LEN_W-1:0]  rx_offset;
	logic [LEN_W-1:0]  rx_len;
	logic [LEN_W-1:0]  chunk_base;
	logic [CRC_W-1:0]  rx_target;
	logic [CRC_W-1:0]  rx_crc;

	receiver_reply_t   awaited_replies[$];
	receiver_reply_t   popped_want;
	int                send_idle_pct;
	int                recv_idle_pct;
	int                stall_cycles = 0;
	int                error_count  = 0;
	int                items_sent   = 0;

	crc_checked_frame_receiver #(
		.ACK_INTERVAL    (ACK_INTERVAL),
		.MAX_FRAME_BYTES (MAX_FRAME_BYTES)
	) uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.cmd          (cmd),
		.frame_length (frame_length),
		.expected_crc (expected_crc),
		.data_byte    (data_byte),
		.chunk_last   (chunk_last),
		.empty        (empty),
		.pop          (pop),
		.status       (status),
		.value        (value),
		.last_result  (last_result)
	);

	always #6 clk = ~clk;

	function automatic logic [CRC_W-1:0] crc32_update(logic [CRC_W-1:0] c, logic [7:0] d);
		logic [CRC_W-1:0] r;
		r = c ^ {24'd0, d};
		repeat (8) r = (r >> 1) ^ (CRC_POLY & {CRC_W{r[0]}});
		return r;
	endfunction

	function automatic logic [CRC_W-1:0] frame_crc(input logic [7:0] bytes[$]);
		logic [CRC_W-1:0] c;
		c = CRC_INIT;
		foreach (bytes[i]) c = crc32_update(c, bytes[i]);
		return ~c;
	endfunction

	function automatic void await_reply(status_t s, logic [CRC_W-1:0] v, logic l);
		receiver_reply_t r;
		r.status = s;
		r.value  = v;
		r.last   = l;
		awaited_replies.push_back(r);
	endfunction

	function automatic void drop_transfer();
		rx_active  = 1'b0;
		rx_offset  = '0;
		rx_target  = '0;
		rx_crc     = CRC_INIT;
		chunk_base = '0;
	endfunction

	function automatic void advance_receiver(cmd_t c, logic [LEN_W-1:0] len,
		logic [CRC_W-1:0] crc, logic [7:0] d, logic l);
		logic [CRC_W-1:0] got;
		got = ~rx_crc;
		case (c)
			CMD_BEGIN: begin
				rx_len     = (len > MAX_FRAME_BYTES) ? LEN_W'(MAX_FRAME_BYTES) : len;
				rx_target  = crc;
				rx_active  = 1'b1;
				rx_offset  = '0;
				rx_crc     = CRC_INIT;
				chunk_base = '0;
				await_reply(ST_READY, '0, 1'b1);
			end
			CMD_ABORT: begin
				drop_transfer();
				await_reply(ST_ABORTED, '0, 1'b1);
			end
			CMD_END: begin
				if (!rx_active || rx_offset != rx_len) begin
					drop_transfer();
					await_reply(ST_LENERR, '0, 1'b1);
				end else if (got != rx_target) begin
					await_reply(ST_CRCFAIL, got, 1'b0);
					await_reply(ST_DONE, '0, 1'b1);
					drop_transfer();
				end else begin
					await_reply(ST_CRCOK, '0, 1'b0);
					await_reply(ST_DONE, '0, 1'b1);
					rx_active = 1'b0;
				end
			end
			CMD_DATA: begin
				if (rx_active) begin
					if (rx_offset < rx_len) begin
						rx_crc    = crc32_update(rx_crc, d);
						rx_offset = rx_offset + 1'b1;
					end
					if (l) begin
						if ((chunk_base / ACK_INTERVAL) != (rx_offset / ACK_INTERVAL) ||
							rx_offset == rx_len)
							await_reply(ST_ACK, CRC_W'(rx_offset), 1'b1);
						chunk_base = rx_offset;
					end
				end
			end
		endcase
	endfunction

	task automatic send_command(cmd_t c, logic [LEN_W-1:0] len, logic [CRC_W-1:0] crc,
		logic [7:0] d, logic l);
		while ($urandom_range(99, 0) < send_idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push         <= 1'b1;
		cmd          <= c;
		frame_length <= len;
		expected_crc <= crc;
		data_byte    <= d;
		chunk_last   <= l;
		do @(posedge clk); while (full);
		advance_receiver(c, len, crc, d, l);
		items_sent++;
	endtask

	task automatic send_begin(logic [LEN_W-1:0] len, logic [CRC_W-1:0] crc);
		send_command(CMD_BEGIN, len, crc, 8'($urandom), 1'($urandom));
	endtask

	task automatic send_data(logic [7:0] d, logic l);
		send_command(CMD_DATA, LEN_W'($urandom), $urandom, d, l);
	endtask

	task automatic send_control(cmd_t c);
		send_command(c, LEN_W'($urandom), $urandom, 8'($urandom), 1'($urandom));
	endtask

	task automatic send_payload(input logic [7:0] bytes[$], input int chunk_odds);
		foreach (bytes[i]) begin
			if (i == bytes.size() - 1)
				send_data(bytes[i], $urandom_range(3, 0) != 0);
			else
				send_data(bytes[i], $urandom_range(chunk_odds - 1, 0) == 0);
		end
	endtask

	task automatic test_idle_commands();
		send_data(8'hFF, 1'b1);
		send_control(CMD_END);
		send_control(CMD_ABORT);
		send_begin(18'h20001, 32'hFFFFFFFF);
		send_control(CMD_END);
		send_begin(18'h3FFFF, 32'h00000000);
		send_control(CMD_ABORT);
	endtask

	task automatic test_crc_check();
		logic [7:0] bytes[$];
		bytes.push_back(8'h00);
		bytes.push_back(8'hFF);
		bytes.push_back(8'hA5);
		send_begin(18'd3, frame_crc(bytes));
		send_data(bytes[0], 1'b0);
		send_data(bytes[1], 1'b0);
		send_data(bytes[2], 1'b1);
		// frame already full, byte dropped but still acked
		send_data(8'h5A, 1'b1);
		send_control(CMD_END);
		send_control(CMD_END);
		// empty frame, crc of nothing is zero
		send_begin(18'd0, 32'hFFFFFFFF);
		send_control(CMD_END);
		send_control(CMD_END);
		send_begin(18'd2, $urandom);
		send_data(8'h3C, 1'b0);
		send_control(CMD_END);
	endtask

	task automatic run_random_frame();
		logic [7:0]       bytes[$];
		logic [CRC_W-1:0] good;
		int               len;
		int               kind;
		kind = $urandom_range(99, 0);
		len  = $urandom_range(24, 0);
		repeat (len) bytes.push_back(8'($urandom));
		good = frame_crc(bytes);
		send_begin(LEN_W'(len), (kind >= 55 && kind < 70) ? good ^ ($urandom | 32'h1) : good);
		if (kind >= 78 && len > 0)
			repeat ($urandom_range(len, 1)) void'(bytes.pop_back());
		send_payload(bytes, 8);
		if (kind >= 70 && kind < 78)
			repeat ($urandom_range(3, 1)) send_data(8'($urandom), 1'($urandom));
		if (kind < 86) begin
			send_control(CMD_END);
		end else if (kind < 93) begin
			send_control(CMD_ABORT);
			if ($urandom_range(1, 0)) send_control(CMD_END);
		end
		// otherwise the frame is left open and the next begin restarts it
	endtask

	task automatic test_random_traffic(input int target);
		int stop_at;
		stop_at = items_sent + target;
		while (items_sent < stop_at) begin
			if ($urandom_range(3, 0) == 0)
				send_command(cmd_t'($urandom_range(3, 0)), LEN_W'($urandom), $urandom,
					8'($urandom), 1'($urandom));
			run_random_frame();
		end
	endtask

	task automatic test_ack_boundaries();
		logic [7:0] bytes[$];
		repeat (520) bytes.push_back(8'($urandom));
		send_begin(18'd520, frame_crc(bytes));
		send_payload(bytes, 16);
		send_control(CMD_END);
	endtask

	task automatic test_oversized_length();
		// oversized length saturates to the maximum, a short frame is a length error
		send_begin(18'h3FFFF, $urandom);
		send_data(8'($urandom), 1'b0);
		send_data(8'($urandom), 1'b1);
		send_control(CMD_END);
	endtask

	function automatic void note_mismatch(string what, logic [CRC_W-1:0] want,
		logic [CRC_W-1:0] got);
		error_count++;
		if (error_count <= REPORT_CAP)
			$display("%0t %s mismatch: expected %h actual %h", $time, what, want, got);
	endfunction

	// result side: check each popped transaction, then pick the next pop
	always @(posedge clk) begin
		if (arst_n && pop && !empty) begin
			if (awaited_replies.size() == 0) begin
				error_count++;
				if (error_count <= REPORT_CAP)
					$display("%0t unexpected transaction: expected none actual %h/%h/%b",
						$time, status, value, last_result);
			end else begin
				popped_want = awaited_replies.pop_front();
				if (status !== popped_want.status)
					note_mismatch("status", CRC_W'(popped_want.status), CRC_W'(status));
				if (value !== popped_want.value)
					note_mismatch("value", popped_want.value, value);
				if (last_result !== popped_want.last)
					note_mismatch("last_result", CRC_W'(popped_want.last), CRC_W'(last_result));
			end
		end
		pop <= arst_n && ($urandom_range(99, 0) >= recv_idle_pct);
	end

	initial begin
		while (stall_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (push && !full) || (pop && !empty))
				stall_cycles = 0;
			else
				stall_cycles++;
		end
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		drop_transfer();
		rx_len        = '0;
		send_idle_pct = 18;
		recv_idle_pct = 88;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		test_idle_commands();
		test_crc_check();
		test_random_traffic(130);

		send_idle_pct = 88;
		recv_idle_pct = 18;
		test_random_traffic(130);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random_traffic(120);
		test_ack_boundaries();
		test_oversized_length();

		push <= 1'b0;
		while (awaited_replies.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
